FILE: rtl/core/tbcm_pkg.sv
// Shared types, codes and helpers for the tile blitter.
package tbcm_pkg;

  localparam int unsigned CoordW   = 10;
  localparam int unsigned PosW     = 8;
  localparam int unsigned ValW     = 8;
  localparam int unsigned SrcDimW  = 5;
  localparam int unsigned DstDimW  = 7;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 7;
  localparam int unsigned LimW     = 8;

  typedef enum logic [1:0] {
    ACT_LOAD = 2'd0,
    ACT_PUT  = 2'd1,
    ACT_DRAW = 2'd2,
    ACT_READ = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    MODE_PLAIN    = 2'd0,
    MODE_TRANSP   = 2'd1,
    MODE_MIRROR_H = 2'd2,
    MODE_MIRROR_V = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    CFG_SRC_W = 2'd0,
    CFG_SRC_H = 2'd1,
    CFG_DST_W = 2'd2,
    CFG_DST_H = 2'd3
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_DRAW,
    ST_DRAW_LAST,
    ST_RESULT
  } state_e;

  typedef logic signed [CoordW-1:0] coord_t;

  function automatic logic coord_inside(coord_t c, logic [LimW-1:0] lim);
    return !c[CoordW-1] && (c[CoordW-2:0] < {1'b0, lim});
  endfunction

endpackage

FILE: rtl/core/tbcm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tbcm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/tile_blitter_clip_mirror_top.sv
// Tile blitter top level: source and target stores, action sequencer, stream ports.
//
// One command beat on the s_axis channel carries an action: load a source
// cell, put a target cell, read a target cell, or draw the whole source tile
// into the target map at a signed origin (plain, transparent zero, mirrored
// horizontally or vertically). Every command returns exactly one beat on
// m_axis with the read value and an in-bounds flag; draw always reports 1.
// Dimensions are set through the cfg_we_i / cfg_idx_i / cfg_data_i write port;
// the user must do so only while the block is idle; the block does not enforce it.
// After reset a clearing pass zeroes both stores, one address per cycle,
// over max(MAX_SRC_W*MAX_SRC_H, MAX_DST_W*MAX_DST_H) addresses (4096 with the
// default sizes); s_axis_tready stays low during the pass.
// From the command beat, load, put and empty draw go straight to the result
// state, read passes ST_READ (registered target RAM read) and draw passes
// ST_DRAW and ST_DRAW_LAST. Draw walks the source tile one cell per cycle
// through the source RAM read port and a column and a row adder, writing at
// most one target cell per cycle. The next command is taken in the cycle
// after the result loads into the output register.
// tready drops until a result sits in the output register, which holds it
// while m_axis_tready is low; the next command is taken meanwhile.
module tile_blitter_clip_mirror_top #(
  parameter int unsigned MAX_SRC_W = 16,
  parameter int unsigned MAX_SRC_H = 16,
  parameter int unsigned MAX_DST_W = 64,
  parameter int unsigned MAX_DST_H = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // action[1:0], draw_mode[3:2], pos_x[11:4], pos_y[19:12], tile_value[27:20]
  input  logic [31:0]                   s_axis_tdata,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // read_tile[7:0], in_bounds[8]
  output logic [15:0]                   m_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  input  logic                          cfg_we_i,
  input  logic [tbcm_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [tbcm_pkg::CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned SRC_DEPTH = MAX_SRC_W * MAX_SRC_H;
  localparam int unsigned DST_DEPTH = MAX_DST_W * MAX_DST_H;
  localparam int unsigned SRC_AW    = (SRC_DEPTH > 1) ? $clog2(SRC_DEPTH) : 1;
  localparam int unsigned DST_AW    = (DST_DEPTH > 1) ? $clog2(DST_DEPTH) : 1;
  localparam int unsigned CLR_DEPTH = (SRC_DEPTH > DST_DEPTH) ? SRC_DEPTH : DST_DEPTH;
  localparam int unsigned CLR_W     = (CLR_DEPTH > 1) ? $clog2(CLR_DEPTH) : 1;

  localparam int unsigned SDW = tbcm_pkg::SrcDimW;
  localparam int unsigned DDW = tbcm_pkg::DstDimW;
  localparam int unsigned VW  = tbcm_pkg::ValW;
  localparam int unsigned LW  = tbcm_pkg::LimW;

  // configuration
  logic [SDW-1:0] src_w_q, src_h_q;
  logic [DDW-1:0] dst_w_q, dst_h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q <= SDW'(16);
      src_h_q <= SDW'(16);
      dst_w_q <= DDW'(64);
      dst_h_q <= DDW'(64);
    end else if (cfg_we_i) begin
      case (tbcm_pkg::cfg_reg_e'(cfg_idx_i))
        tbcm_pkg::CFG_SRC_W: src_w_q <= cfg_data_i[SDW-1:0];
        tbcm_pkg::CFG_SRC_H: src_h_q <= cfg_data_i[SDW-1:0];
        tbcm_pkg::CFG_DST_W: dst_w_q <= cfg_data_i[DDW-1:0];
        tbcm_pkg::CFG_DST_H: dst_h_q <= cfg_data_i[DDW-1:0];
        default: ;
      endcase
    end
  end

  logic [SDW-1:0] eff_src_w, eff_src_h;
  logic [DDW-1:0] eff_dst_w, eff_dst_h;
  logic [LW-1:0]  lim_src_w, lim_src_h, lim_dst_w, lim_dst_h;

  assign eff_src_w = (32'(src_w_q) > MAX_SRC_W) ? SDW'(MAX_SRC_W) : src_w_q;
  assign eff_src_h = (32'(src_h_q) > MAX_SRC_H) ? SDW'(MAX_SRC_H) : src_h_q;
  assign eff_dst_w = (32'(dst_w_q) > MAX_DST_W) ? DDW'(MAX_DST_W) : dst_w_q;
  assign eff_dst_h = (32'(dst_h_q) > MAX_DST_H) ? DDW'(MAX_DST_H) : dst_h_q;
  assign lim_src_w = LW'(eff_src_w);
  assign lim_src_h = LW'(eff_src_h);
  assign lim_dst_w = LW'(eff_dst_w);
  assign lim_dst_h = LW'(eff_dst_h);

  // command fields
  tbcm_pkg::action_e       in_action;
  tbcm_pkg::mode_e         in_mode;
  logic signed [7:0]       in_x, in_y;
  logic [VW-1:0]           in_val;
  tbcm_pkg::coord_t        in_cx, in_cy;
  logic                    in_src_ok, in_dst_ok;
  logic [SRC_AW-1:0]       in_src_addr;
  logic [DST_AW-1:0]       in_dst_addr;

  assign in_action = tbcm_pkg::action_e'(s_axis_tdata[1:0]);
  assign in_mode   = tbcm_pkg::mode_e'(s_axis_tdata[3:2]);
  assign in_x      = s_axis_tdata[11:4];
  assign in_y      = s_axis_tdata[19:12];
  assign in_val    = s_axis_tdata[27:20];
  assign in_cx     = tbcm_pkg::coord_t'(in_x);
  assign in_cy     = tbcm_pkg::coord_t'(in_y);

  assign in_src_ok = tbcm_pkg::coord_inside(in_cx, lim_src_w)
                  && tbcm_pkg::coord_inside(in_cy, lim_src_h);
  assign in_dst_ok = tbcm_pkg::coord_inside(in_cx, lim_dst_w)
                  && tbcm_pkg::coord_inside(in_cy, lim_dst_h);
  assign in_src_addr = SRC_AW'(32'(in_cy[SDW-1:0]) * MAX_SRC_W + 32'(in_cx[SDW-1:0]));
  assign in_dst_addr = DST_AW'(32'(in_cy[DDW-1:0]) * MAX_DST_W + 32'(in_cx[DDW-1:0]));

  // sequencer state
  tbcm_pkg::state_e state_q, state_d;
  logic [CLR_W-1:0] clr_cnt_q, clr_cnt_d;
  logic [SDW-1:0]   ix_q, ix_d, iy_q, iy_d;
  tbcm_pkg::mode_e  mode_q, mode_d;
  tbcm_pkg::coord_t px_q, px_d, py_q, py_d;
  logic             p_valid_q, p_valid_d;
  tbcm_pkg::coord_t p_x_q, p_x_d, p_y_q, p_y_d;
  logic [VW-1:0]    res_rd_q, res_rd_d;
  logic             res_ok_q, res_ok_d;
  logic [VW-1:0]    out_rd_q, out_rd_d;
  logic             out_ok_q, out_ok_d;
  logic             m_valid_q, m_valid_d;

  logic             accept, out_load;
  logic [SDW-1:0]   ix_nxt;
  logic             last_col, last_row, src_empty;
  tbcm_pkg::coord_t ix_c, iy_c, draw_x, draw_y;
  logic [SRC_AW-1:0] draw_src_addr;
  logic [DST_AW-1:0] p_dst_addr;
  logic              p_write;

  logic              src_we, dst_we;
  logic [SRC_AW-1:0] src_waddr;
  logic [DST_AW-1:0] dst_waddr;
  logic [VW-1:0]     src_wdata, dst_wdata, src_rdata, dst_rdata;

  assign accept    = s_axis_tvalid && s_axis_tready;
  assign out_load  = (state_q == tbcm_pkg::ST_RESULT) && (!m_valid_q || m_axis_tready);
  assign src_empty = (eff_src_w == '0) || (eff_src_h == '0);

  assign ix_nxt   = ix_q + SDW'(1);
  assign last_col = (ix_nxt == eff_src_w);
  assign last_row = ((iy_q + SDW'(1)) == eff_src_h);
  assign ix_c     = tbcm_pkg::coord_t'(ix_q);
  assign iy_c     = tbcm_pkg::coord_t'(iy_q);
  assign draw_x   = (mode_q == tbcm_pkg::MODE_MIRROR_H) ? px_q - ix_c : px_q + ix_c;
  assign draw_y   = (mode_q == tbcm_pkg::MODE_MIRROR_V) ? py_q - iy_c : py_q + iy_c;
  assign draw_src_addr = SRC_AW'(32'(iy_q) * MAX_SRC_W + 32'(ix_q));

  assign p_dst_addr = DST_AW'(32'(p_y_q[DDW-1:0]) * MAX_DST_W + 32'(p_x_q[DDW-1:0]));
  assign p_write = p_valid_q
                && tbcm_pkg::coord_inside(p_x_q, lim_dst_w)
                && tbcm_pkg::coord_inside(p_y_q, lim_dst_h)
                && !((mode_q == tbcm_pkg::MODE_TRANSP) && (src_rdata == '0));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      tbcm_pkg::ST_CLEAR: begin
        if (clr_cnt_q == CLR_W'(CLR_DEPTH - 1)) state_d = tbcm_pkg::ST_IDLE;
      end
      tbcm_pkg::ST_IDLE: begin
        if (accept) begin
          case (in_action)
            tbcm_pkg::ACT_READ: state_d = tbcm_pkg::ST_READ;
            tbcm_pkg::ACT_DRAW: state_d = src_empty ? tbcm_pkg::ST_RESULT
                                                    : tbcm_pkg::ST_DRAW;
            default:            state_d = tbcm_pkg::ST_RESULT;
          endcase
        end
      end
      tbcm_pkg::ST_READ:      state_d = tbcm_pkg::ST_RESULT;
      tbcm_pkg::ST_DRAW: begin
        if (last_col && last_row) state_d = tbcm_pkg::ST_DRAW_LAST;
      end
      tbcm_pkg::ST_DRAW_LAST: state_d = tbcm_pkg::ST_RESULT;
      tbcm_pkg::ST_RESULT: begin
        if (out_load) state_d = tbcm_pkg::ST_IDLE;
      end
      default:                state_d = tbcm_pkg::ST_CLEAR;
    endcase
  end

  // outputs: handshake and memory write port selection
  always_comb begin
    s_axis_tready = (state_q == tbcm_pkg::ST_IDLE);
    src_we    = 1'b0;
    src_waddr = in_src_addr;
    src_wdata = in_val;
    dst_we    = 1'b0;
    dst_waddr = in_dst_addr;
    dst_wdata = in_val;
    if (state_q == tbcm_pkg::ST_CLEAR) begin
      src_we    = (32'(clr_cnt_q) < SRC_DEPTH);
      src_waddr = SRC_AW'(clr_cnt_q);
      src_wdata = '0;
      dst_we    = (32'(clr_cnt_q) < DST_DEPTH);
      dst_waddr = DST_AW'(clr_cnt_q);
      dst_wdata = '0;
    end else if (p_write) begin
      dst_we    = 1'b1;
      dst_waddr = p_dst_addr;
      dst_wdata = src_rdata;
    end else if (accept) begin
      src_we = (in_action == tbcm_pkg::ACT_LOAD) && in_src_ok;
      dst_we = (in_action == tbcm_pkg::ACT_PUT) && in_dst_ok;
    end
  end

  // datapath next values
  always_comb begin
    clr_cnt_d = clr_cnt_q;
    ix_d      = ix_q;
    iy_d      = iy_q;
    mode_d    = mode_q;
    px_d      = px_q;
    py_d      = py_q;
    p_valid_d = 1'b0;
    p_x_d     = p_x_q;
    p_y_d     = p_y_q;
    res_rd_d  = res_rd_q;
    res_ok_d  = res_ok_q;
    out_rd_d  = out_rd_q;
    out_ok_d  = out_ok_q;
    m_valid_d = m_valid_q && !m_axis_tready;

    case (state_q)
      tbcm_pkg::ST_CLEAR: clr_cnt_d = clr_cnt_q + CLR_W'(1);
      tbcm_pkg::ST_IDLE: begin
        if (accept) begin
          mode_d   = in_mode;
          px_d     = in_cx;
          py_d     = in_cy;
          ix_d     = '0;
          iy_d     = '0;
          res_rd_d = '0;
          case (in_action)
            tbcm_pkg::ACT_LOAD: res_ok_d = in_src_ok;
            tbcm_pkg::ACT_DRAW: res_ok_d = 1'b1;
            default:            res_ok_d = in_dst_ok;
          endcase
        end
      end
      tbcm_pkg::ST_READ: res_rd_d = res_ok_q ? dst_rdata : '0;
      tbcm_pkg::ST_DRAW: begin
        p_valid_d = 1'b1;
        p_x_d     = draw_x;
        p_y_d     = draw_y;
        if (last_col) begin
          ix_d = '0;
          iy_d = iy_q + SDW'(1);
        end else begin
          ix_d = ix_nxt;
        end
      end
      default: ;
    endcase

    if (out_load) begin
      out_rd_d  = res_rd_q;
      out_ok_d  = res_ok_q;
      m_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= tbcm_pkg::ST_CLEAR;
      clr_cnt_q <= '0;
      p_valid_q <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
      p_valid_q <= p_valid_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ix_q     <= ix_d;
    iy_q     <= iy_d;
    mode_q   <= mode_d;
    px_q     <= px_d;
    py_q     <= py_d;
    p_x_q    <= p_x_d;
    p_y_q    <= p_y_d;
    res_rd_q <= res_rd_d;
    res_ok_q <= res_ok_d;
    out_rd_q <= out_rd_d;
    out_ok_q <= out_ok_d;
  end

  tbcm_ram #(
    .WIDTH (VW),
    .DEPTH (SRC_DEPTH)
  ) u_src_ram (
    .clk_i   (clk_i),
    .we_i    (src_we),
    .waddr_i (src_waddr),
    .wdata_i (src_wdata),
    .raddr_i (draw_src_addr),
    .rdata_o (src_rdata)
  );

  tbcm_ram #(
    .WIDTH (VW),
    .DEPTH (DST_DEPTH)
  ) u_dst_ram (
    .clk_i   (clk_i),
    .we_i    (dst_we),
    .waddr_i (dst_waddr),
    .wdata_i (dst_wdata),
    .raddr_i (in_dst_addr),
    .rdata_o (dst_rdata)
  );

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {7'b0, out_ok_q, out_rd_q};

endmodule
